FILE: rtl/core/motor_speed_ramp_limiter_defines.svh
// ----------------------------------------------------------------------------
// motor speed ramp limiter assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_LIMITER_DEFINES_SVH
`define MOTOR_SPEED_RAMP_LIMITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MSRL_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msrl same-cycle check failed");

// next-cycle implication
`define MSRL_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msrl next-cycle check failed");

`else

`define MSRL_ASSERT_IMP(name, clk, rst, ante, cons)
`define MSRL_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/msrl_pkg.sv
// ----------------------------------------------------------------------------
// msrl package
// shared types, register codes and clamp helper of the speed ramp limiter
// ----------------------------------------------------------------------------
`default_nettype none

package msrl_pkg;

   // number of motor channels with stored speed
   localparam int Channels = 2;

   // depth of each internal item queue
   localparam int QueueDepth = 2;

   // register index codes
   localparam int CsrIndexW = 3;
   localparam logic [CsrIndexW-1:0] CsrAccelStep = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrDecelStep = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrSpeedUpper = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrSpeedLower = 3'd3;
   localparam logic [CsrIndexW-1:0] CsrDeadBand = 3'd4;

   // register reset values
   localparam logic [14:0] AccelReset = 15'd10;
   localparam logic [14:0] DecelReset = 15'd10;
   localparam logic [14:0] UpperReset = 15'd1000;
   localparam logic signed [15:0] LowerReset = -16'sd1000;
   localparam logic [14:0] DeadBandReset = 15'd0;

   // direction codes
   localparam logic [1:0] DirStop = 2'd0;
   localparam logic [1:0] DirFwd = 2'd1;
   localparam logic [1:0] DirBack = 2'd2;

   typedef struct packed {
      logic channel;
      logic signed [15:0] target_speed;
   } msrl_req_type;

   typedef struct packed {
      logic out_channel;
      logic signed [15:0] applied_speed;
      logic [14:0] pwm_magnitude;
      logic [1:0] direction;
   } msrl_rsp_type;

   typedef struct packed {
      logic [14:0] accel_step;
      logic [14:0] decel_step;
      logic [14:0] speed_upper;
      logic signed [15:0] speed_lower;
      logic [14:0] dead_band;
   } msrl_cfg_type;

   // one queued item: channel, channel in range, speed
   typedef struct packed {
      logic channel;
      logic in_range;
      logic signed [15:0] speed;
   } msrl_slot_type;

   // clamp to [speed_lower, speed_upper], upper tested first
   function automatic logic signed [15:0] msrl_clamp(input logic signed [17:0] v,
                                                     input msrl_cfg_type cfg);
      logic signed [17:0] upper;
      logic signed [17:0] lower;
      logic signed [15:0] res;
      upper = $signed({3'b000, cfg.speed_upper});
      lower = $signed({{2{cfg.speed_lower[15]}}, cfg.speed_lower});
      if (v > upper) begin
         res = upper[15:0];
      end else if (v < lower) begin
         res = lower[15:0];
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/msrl_csr.sv
// ----------------------------------------------------------------------------
// msrl configuration registers
// holds step sizes, speed limits and dead band, written through the csr port
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [msrl_pkg::CsrIndexW-1:0]     csr_index,
   input  wire logic [15:0]                        csr_wdata,
   output      msrl_pkg::msrl_cfg_type             cfg
);

   msrl_pkg::msrl_cfg_type cfg_ff;
   msrl_pkg::msrl_cfg_type cfg_in;

   // writes always taken
   assign csr_ready = 1'b1;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            msrl_pkg::CsrAccelStep:  cfg_in.accel_step = csr_wdata[14:0];
            msrl_pkg::CsrDecelStep:  cfg_in.decel_step = csr_wdata[14:0];
            msrl_pkg::CsrSpeedUpper: cfg_in.speed_upper = csr_wdata[14:0];
            msrl_pkg::CsrSpeedLower: cfg_in.speed_lower = $signed(csr_wdata);
            msrl_pkg::CsrDeadBand:   cfg_in.dead_band = csr_wdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_step <= msrl_pkg::AccelReset;
         cfg_ff.decel_step <= msrl_pkg::DecelReset;
         cfg_ff.speed_upper <= msrl_pkg::UpperReset;
         cfg_ff.speed_lower <= msrl_pkg::LowerReset;
         cfg_ff.dead_band <= msrl_pkg::DeadBandReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/msrl_queue.sv
// ----------------------------------------------------------------------------
// msrl item queue
// small first-in first-out buffer of flip-flops between two pipeline parts
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire msrl_pkg::msrl_slot_type wr_data,
   output      logic                    full,
   input  wire logic                    pop,
   output      logic                    empty,
   output      msrl_pkg::msrl_slot_type rd_data
);

   localparam int PtrW = (msrl_pkg::QueueDepth > 1) ? $clog2(msrl_pkg::QueueDepth) : 1;
   localparam int CountW = $clog2(msrl_pkg::QueueDepth + 1);

   msrl_pkg::msrl_slot_type entries_ff [msrl_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              push_ok;
   logic              pop_ok;

   assign full = (count_ff == CountW'(msrl_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok = pop && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(msrl_pkg::QueueDepth - 1)) ? '0 :
                     wr_ptr_ff + PtrW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(msrl_pkg::QueueDepth - 1)) ? '0 :
                     rd_ptr_ff + PtrW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CountW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/msrl_front.sv
// ----------------------------------------------------------------------------
// msrl front end
// accepts requests, checks the channel and clamps the target to the limits
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_front (
   input  wire logic                    req_push,
   output      logic                    req_full,
   input  wire msrl_pkg::msrl_req_type  req_item,
   input  wire msrl_pkg::msrl_cfg_type  cfg,
   input  wire logic                    q_full,
   output      logic                    q_push,
   output      msrl_pkg::msrl_slot_type q_data
);

   logic signed [17:0] target_ext;

   // accept while the work queue has room
   assign req_full = q_full;
   assign q_push = req_push && !q_full;

   // classify channel and clamp target
   assign target_ext = $signed({{2{req_item.target_speed[15]}}, req_item.target_speed});
   always_comb begin
      q_data.channel = req_item.channel;
      q_data.in_range = ({31'd0, req_item.channel} < 32'(msrl_pkg::Channels));
      q_data.speed = msrl_pkg::msrl_clamp(target_ext, cfg);
   end

endmodule

`default_nettype wire

FILE: rtl/core/msrl_back.sv
// ----------------------------------------------------------------------------
// msrl back end
// per-channel speed registers and the ramp step toward the clamped target
// ----------------------------------------------------------------------------
`default_nettype none

module msrl_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire msrl_pkg::msrl_cfg_type  cfg,
   input  wire logic                    in_empty,
   input  wire msrl_pkg::msrl_slot_type in_data,
   output      logic                    in_pop,
   input  wire logic                    out_full,
   output      logic                    out_push,
   output      msrl_pkg::msrl_slot_type out_data
);

   logic signed [15:0] speed_ff [msrl_pkg::Channels];
   logic signed [15:0] speed_in [msrl_pkg::Channels];
   logic               fire;
   logic signed [15:0] cur;
   logic signed [17:0] cur_ext;
   logic signed [17:0] tgt_ext;
   logic signed [17:0] diff;
   logic signed [17:0] up_step;
   logic signed [17:0] dn_step;
   logic signed [17:0] ramped;
   logic signed [15:0] next_speed;

   // one item per cycle when both queues allow
   assign fire = !in_empty && !out_full;
   assign in_pop = fire;
   assign out_push = fire;

   // ramp toward target, steps mirrored for negative speed
   assign cur = speed_ff[in_data.channel];
   assign cur_ext = $signed({{2{cur[15]}}, cur});
   assign tgt_ext = $signed({{2{in_data.speed[15]}}, in_data.speed});
   assign diff = tgt_ext - cur_ext;
   assign up_step = cur[15] ? $signed({3'b000, cfg.decel_step}) :
                              $signed({3'b000, cfg.accel_step});
   assign dn_step = cur[15] ? $signed({3'b000, cfg.accel_step}) :
                              $signed({3'b000, cfg.decel_step});

   always_comb begin
      if (diff > up_step) begin
         ramped = cur_ext + up_step;
      end else if (-diff > dn_step) begin
         ramped = cur_ext - dn_step;
      end else begin
         ramped = tgt_ext;
      end
   end

   assign next_speed = msrl_pkg::msrl_clamp(ramped, cfg);

   // result to the output queue, zero speed for a channel out of range
   always_comb begin
      out_data.channel = in_data.channel;
      out_data.in_range = in_data.in_range;
      out_data.speed = in_data.in_range ? next_speed : 16'sd0;
   end

   // speed register update
   always_comb begin
      speed_in = speed_ff;
      if (fire && in_data.in_range) begin
         speed_in[in_data.channel] = next_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msrl_pkg::Channels; i++) begin
            speed_ff[i] <= '0;
         end
      end else begin
         speed_ff <= speed_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/motor_speed_ramp_limiter.sv
// ----------------------------------------------------------------------------
// motor speed ramp limiter
// path: request -> work queue -> ramp in back end -> result queue
// throughput: one item per cycle; stalls on empty work or full result queue
// reset: synchronous; clears queues and channel speeds, loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_speed_ramp_limiter_defines.svh"

module motor_speed_ramp_limiter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output      logic                                req_full,
   input  wire msrl_pkg::msrl_req_type              req_item,
   output      logic                                rsp_empty,
   input  wire logic                                rsp_pop,
   output      msrl_pkg::msrl_rsp_type              rsp_item,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [msrl_pkg::CsrIndexW-1:0]      csr_index,
   input  wire logic [15:0]                         csr_wdata
);

   msrl_pkg::msrl_cfg_type  cfg;
   msrl_pkg::msrl_slot_type front_data;
   msrl_pkg::msrl_slot_type mid_data;
   msrl_pkg::msrl_slot_type back_data;
   msrl_pkg::msrl_slot_type head;
   logic                    front_push;
   logic                    mid_full;
   logic                    mid_empty;
   logic                    mid_pop;
   logic                    back_push;
   logic                    out_full;
   logic signed [16:0]      head_ext;
   logic signed [16:0]      band_ext;
   logic signed [16:0]      neg_ext;
   logic                    head_stop;
   logic                    head_clear;
   logic                    head_fwd;
   logic                    head_fwd_ok;

   // configuration registers
   msrl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // request intake
   msrl_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .cfg      (cfg),
      .q_full   (mid_full),
      .q_push   (front_push),
      .q_data   (front_data)
   );

   // work queue between front and back
   msrl_queue u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (front_data),
      .full    (mid_full),
      .pop     (mid_pop),
      .empty   (mid_empty),
      .rd_data (mid_data)
   );

   // ramp and state update
   msrl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_empty (mid_empty),
      .in_data  (mid_data),
      .in_pop   (mid_pop),
      .out_full (out_full),
      .out_push (back_push),
      .out_data (back_data)
   );

   // result queue
   msrl_queue u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (head)
   );

   // dead band, direction and pwm magnitude of the oldest result
   assign head_ext = $signed({head.speed[15], head.speed});
   assign band_ext = $signed({2'b00, cfg.dead_band});
   assign neg_ext = -head_ext;

   always_comb begin
      rsp_item.out_channel = head.channel;
      if (head_ext > band_ext) begin
         rsp_item.applied_speed = head.speed;
         rsp_item.pwm_magnitude = head.speed[14:0];
         rsp_item.direction = msrl_pkg::DirFwd;
      end else if (head_ext < -band_ext) begin
         rsp_item.applied_speed = head.speed;
         rsp_item.pwm_magnitude = (neg_ext > 17'sd32767) ? 15'h7fff : neg_ext[14:0];
         rsp_item.direction = msrl_pkg::DirBack;
      end else begin
         rsp_item.applied_speed = '0;
         rsp_item.pwm_magnitude = '0;
         rsp_item.direction = msrl_pkg::DirStop;
      end
   end

   // conditions watched by the checks
   assign head_stop = !rsp_empty && rsp_item.direction == msrl_pkg::DirStop;
   assign head_clear = rsp_item.applied_speed == 16'sd0 && rsp_item.pwm_magnitude == 15'd0;
   assign head_fwd = !rsp_empty && rsp_item.direction == msrl_pkg::DirFwd;
   assign head_fwd_ok = rsp_item.applied_speed > 16'sd0 &&
                        rsp_item.pwm_magnitude == rsp_item.applied_speed[14:0];

   // checks
   `MSRL_ASSERT_NEXT(a_push_lands, clock, reset, req_push && !req_full, !mid_empty)
   `MSRL_ASSERT_IMP(a_stop_zero, clock, reset, head_stop, head_clear)
   `MSRL_ASSERT_IMP(a_fwd_mag, clock, reset, head_fwd, head_fwd_ok)

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor speed ramp limiter testbench
// drives signed target speeds per channel through the push/pop queues, with
// random idle gaps on both sides, and rewrites the limit registers between
// phases. an in-bench ramp predictor computes every expected drive result,
// and each popped item is compared field by field in order. a short directed
// table covers the extremes, crossed limits, the deadzone and full negative
// speed, then random phases follow with fresh register settings.
// ----------------------------------------------------------------------------

module testbench;

   // register indexes with no register behind them
   localparam logic [msrl_pkg::CsrIndexW-1:0] CsrNoRegFirst = 3'd5;
   localparam logic [msrl_pkg::CsrIndexW-1:0] CsrNoRegLast = 3'd7;

   localparam int RandomItems = 1450;
   localparam int TailCycles = 8;
   localparam int LimitNs = 400000;
   localparam int ReportLimit = 10;

   typedef enum logic {RowTarget, RowCsr} row_kind_type;

   typedef struct {
      row_kind_type kind;
      msrl_pkg::msrl_req_type req;
      logic typed;
      msrl_pkg::msrl_rsp_type want;
      logic [msrl_pkg::CsrIndexW-1:0] index;
      logic [15:0] data;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   msrl_pkg::msrl_req_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   msrl_pkg::msrl_rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [msrl_pkg::CsrIndexW-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor state and register copy
   logic signed [15:0] chan_speed [msrl_pkg::Channels];
   msrl_pkg::msrl_cfg_type lim_cfg;

   msrl_pkg::msrl_rsp_type pending_drive [$];
   stim_row_type stim_rows [$];
   int mismatch_count = 0;
   logic push_high = 1'b0;
   logic send_idle_on = 1'b1;
   logic recv_idle_on = 1'b1;

   motor_speed_ramp_limiter dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_item(req_item),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hard stop for a hung run
   initial begin
      #LimitNs;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic logic signed [17:0] sext18(input logic [15:0] v);
      return $signed({v[15], v[15], v});
   endfunction

   // when the limits cross, a value above the upper limit gets it and any other the lower
   function automatic logic signed [17:0] fit_limits(input logic signed [17:0] v);
      logic signed [17:0] hi;
      logic signed [17:0] lo;
      hi = {3'b000, lim_cfg.speed_upper};
      lo = sext18(lim_cfg.speed_lower);
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // ramp one channel toward its target and shape the drive item
   function automatic msrl_pkg::msrl_rsp_type ramp_speed(input msrl_pkg::msrl_req_type rq);
      msrl_pkg::msrl_rsp_type res;
      logic signed [17:0] tgt;
      logic signed [17:0] cur;
      logic signed [17:0] nxt;
      logic signed [17:0] acc;
      logic signed [17:0] dec;
      logic signed [17:0] band;
      logic signed [17:0] mag;
      acc = {3'b000, lim_cfg.accel_step};
      dec = {3'b000, lim_cfg.decel_step};
      band = {3'b000, lim_cfg.dead_band};
      tgt = fit_limits(sext18(rq.target_speed));
      cur = sext18(chan_speed[rq.channel]);
      // growing magnitude uses accel, shrinking uses decel, mirrored below zero
      if (cur >= 0) begin
         if (tgt - cur > acc) begin
            nxt = cur + acc;
         end else if (cur - tgt > dec) begin
            nxt = cur - dec;
         end else begin
            nxt = tgt;
         end
      end else begin
         if (cur - tgt > acc) begin
            nxt = cur - acc;
         end else if (tgt - cur > dec) begin
            nxt = cur + dec;
         end else begin
            nxt = tgt;
         end
      end
      nxt = fit_limits(nxt);
      // stored speed keeps the ramped value even inside the deadzone
      chan_speed[rq.channel] = nxt[15:0];
      res.out_channel = rq.channel;
      if (nxt > band) begin
         res.applied_speed = nxt[15:0];
         res.direction = msrl_pkg::DirFwd;
         mag = nxt;
      end else if (nxt < -band) begin
         res.applied_speed = nxt[15:0];
         res.direction = msrl_pkg::DirBack;
         mag = -nxt;
      end else begin
         res.applied_speed = '0;
         res.direction = msrl_pkg::DirStop;
         mag = '0;
      end
      if (mag > 18'sd32767) begin
         mag = 18'sd32767;
      end
      res.pwm_magnitude = mag[14:0];
      return res;
   endfunction

   // register write as seen by the predictor
   function automatic void note_csr_write(input logic [msrl_pkg::CsrIndexW-1:0] idx,
                                          input logic [15:0] data);
      case (idx)
         msrl_pkg::CsrAccelStep: lim_cfg.accel_step = data[14:0];
         msrl_pkg::CsrDecelStep: lim_cfg.decel_step = data[14:0];
         msrl_pkg::CsrSpeedUpper: lim_cfg.speed_upper = data[14:0];
         msrl_pkg::CsrSpeedLower: lim_cfg.speed_lower = data;
         msrl_pkg::CsrDeadBand: lim_cfg.dead_band = data[14:0];
         default: ;
      endcase
   endfunction

   // random register value, extremes included, bit 15 random on 15-bit fields
   function automatic logic [15:0] random_csr(input logic [msrl_pkg::CsrIndexW-1:0] idx);
      logic [15:0] v;
      int pick;
      pick = $urandom_range(0, 7);
      v = 16'($urandom);
      case (idx)
         msrl_pkg::CsrAccelStep, msrl_pkg::CsrDecelStep: begin
            case (pick)
               0: v[14:0] = '0;
               1: v[14:0] = '1;
               2, 3, 4: v[14:0] = 15'($urandom_range(1, 60));
               5, 6: v[14:0] = 15'($urandom_range(61, 2000));
               default: ;
            endcase
         end
         msrl_pkg::CsrSpeedUpper: begin
            case (pick)
               0: v[14:0] = '0;
               1: v[14:0] = '1;
               2, 3, 4, 5: v[14:0] = 15'($urandom_range(100, 3000));
               default: ;
            endcase
         end
         msrl_pkg::CsrSpeedLower: begin
            case (pick)
               0: v = 16'h8000;
               1: v = '0;
               2, 3, 4, 5: v = 16'(-$urandom_range(100, 3000));
               6: v = 16'(-$urandom_range(0, 32767));
               default: ;
            endcase
         end
         default: begin
            case (pick)
               0, 1, 2: v[14:0] = '0;
               3, 4, 5: v[14:0] = 15'($urandom_range(1, 150));
               6: v[14:0] = '1;
               default: ;
            endcase
         end
      endcase
      return v;
   endfunction

   // target mix: full range, extremes, inside the limits, near the current speed
   function automatic logic signed [15:0] choose_target(input logic ch);
      int lo;
      int hi;
      int span;
      int t;
      lo = int'(lim_cfg.speed_lower);
      hi = int'(lim_cfg.speed_upper);
      t = $urandom;
      case ($urandom_range(0, 9))
         0, 1: ;
         2: begin
            case ($urandom_range(0, 3))
               0: t = -32768;
               1: t = 32767;
               2: t = 0;
               default: t = -1;
            endcase
         end
         3, 4, 5, 6: begin
            if (lo <= hi) begin
               t = lo + int'($urandom_range(0, hi - lo));
            end
         end
         default: begin
            span = lim_cfg.accel_step > lim_cfg.decel_step ?
                   int'(lim_cfg.accel_step) : int'(lim_cfg.decel_step);
            span = span + 8;
            t = int'(chan_speed[ch]);
            t = t + int'($urandom_range(0, 2 * span)) - span;
            if (t > 32767) begin
               t = 32767;
            end
            if (t < -32768) begin
               t = -32768;
            end
         end
      endcase
      return t[15:0];
   endfunction

   function automatic void add_target(input logic ch, input logic [15:0] tgt);
      stim_row_type row;
      row = '{kind: RowTarget, req: '{ch, tgt}, typed: 1'b0, want: '0,
              index: '0, data: '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_checked(input logic ch, input logic [15:0] tgt,
                                       input logic [15:0] speed,
                                       input logic [14:0] pwm,
                                       input logic [1:0] dir);
      stim_row_type row;
      row = '{kind: RowTarget, req: '{ch, tgt}, typed: 1'b1,
              want: '{ch, speed, pwm, dir}, index: '0, data: '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [msrl_pkg::CsrIndexW-1:0] idx,
                                   input logic [15:0] data);
      stim_row_type row;
      row = '{kind: RowCsr, req: '0, typed: 1'b0, want: '0, index: idx, data: data};
      stim_rows.push_back(row);
   endfunction

   // push one item, record its expected drive item once accepted
   task automatic send_target(input msrl_pkg::msrl_req_type rq, input logic typed,
                              input msrl_pkg::msrl_rsp_type want);
      int gap;
      msrl_pkg::msrl_rsp_type model_rsp;
      gap = send_idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         if (push_high) begin
            req_push <= 1'b0;
            push_high = 1'b0;
         end
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      push_high = 1'b1;
      req_item <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      model_rsp = ramp_speed(rq);
      pending_drive.push_back(typed ? want : model_rsp);
      @(negedge clock);
   endtask

   // stop pushing and wait for every expected item to be popped
   task automatic drain_results();
      if (push_high) begin
         req_push <= 1'b0;
         push_high = 1'b0;
         @(negedge clock);
      end
      while (pending_drive.size() != 0) @(negedge clock);
   endtask

   // one register write; valid is left high for a following write
   task automatic write_csr(input logic [msrl_pkg::CsrIndexW-1:0] idx,
                            input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      note_csr_write(idx, data);
      @(negedge clock);
   endtask

   // result side: random stalls, in-order compare
   initial begin
      int stall;
      msrl_pkg::msrl_rsp_type got;
      msrl_pkg::msrl_rsp_type want;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         stall = recv_idle_on ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         got = rsp_item;
         if (pending_drive.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
               $display("unexpected item: ch %0d speed %0d pwm %0d dir %0d",
                        got.out_channel, got.applied_speed, got.pwm_magnitude,
                        got.direction);
            end
         end else begin
            want = pending_drive.pop_front();
            if (got.out_channel !== want.out_channel ||
                got.applied_speed !== want.applied_speed ||
                got.pwm_magnitude !== want.pwm_magnitude ||
                got.direction !== want.direction) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit) begin
                  $display("mismatch: exp ch %0d speed %0d pwm %0d dir %0d",
                           want.out_channel, want.applied_speed,
                           want.pwm_magnitude, want.direction);
                  $display("           got ch %0d speed %0d pwm %0d dir %0d",
                           got.out_channel, got.applied_speed,
                           got.pwm_magnitude, got.direction);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type row;
      msrl_pkg::msrl_req_type rq;
      logic csr_open;
      int sent;
      int left;

      // predictor starts from the reset state
      foreach (chan_speed[i]) chan_speed[i] = '0;
      lim_cfg.accel_step = msrl_pkg::AccelReset;
      lim_cfg.decel_step = msrl_pkg::DecelReset;
      lim_cfg.speed_upper = msrl_pkg::UpperReset;
      lim_cfg.speed_lower = msrl_pkg::LowerReset;
      lim_cfg.dead_band = msrl_pkg::DeadBandReset;

      // reset defaults, targets far beyond the limits
      add_checked(1'b0, 16'sd32767, 16'sd10, 15'd10, msrl_pkg::DirFwd);
      add_checked(1'b1, -16'sd32768, -16'sd10, 15'd10, msrl_pkg::DirBack);
      add_target(1'b0, 16'sd0);
      add_target(1'b0, 16'sd5);
      add_target(1'b1, -16'sd3);
      // widest limits and steps, bit 15 ignored on 15-bit registers
      add_csr(msrl_pkg::CsrAccelStep, 16'hFFFF);
      add_csr(msrl_pkg::CsrDecelStep, 16'h7FFF);
      add_csr(msrl_pkg::CsrSpeedUpper, 16'hFFFF);
      add_csr(msrl_pkg::CsrSpeedLower, 16'h8000);
      add_csr(msrl_pkg::CsrDeadBand, 16'h8000);
      add_csr(CsrNoRegFirst, 16'h0001);
      add_csr(CsrNoRegLast, 16'hFFFF);
      // full negative speed saturates the pwm magnitude
      add_checked(1'b1, -16'sd32768, -16'sd32768, 15'd32767, msrl_pkg::DirBack);
      add_checked(1'b0, 16'sd32767, 16'sd32767, 15'd32767, msrl_pkg::DirFwd);
      add_target(1'b0, -16'sd32768);
      add_target(1'b1, 16'sd32767);
      // zero steps freeze the speed
      add_csr(msrl_pkg::CsrAccelStep, 16'h8000);
      add_csr(msrl_pkg::CsrDecelStep, 16'h0000);
      add_target(1'b0, 16'sd100);
      add_target(1'b1, -16'sd5);
      // crossed limits
      add_csr(msrl_pkg::CsrAccelStep, 16'd1000);
      add_csr(msrl_pkg::CsrDecelStep, 16'd1000);
      add_csr(msrl_pkg::CsrSpeedUpper, 16'd100);
      add_csr(msrl_pkg::CsrSpeedLower, 16'd200);
      add_csr(msrl_pkg::CsrDeadBand, 16'd50);
      add_target(1'b0, -16'sd500);
      add_target(1'b1, 16'sd32767);
      add_target(1'b0, 16'sd150);
      // widest deadzone: speed still ramps underneath the stop
      add_csr(msrl_pkg::CsrAccelStep, 16'd300);
      add_csr(msrl_pkg::CsrDecelStep, 16'd300);
      add_csr(msrl_pkg::CsrSpeedUpper, 16'd1000);
      add_csr(msrl_pkg::CsrSpeedLower, -16'sd1000);
      add_csr(msrl_pkg::CsrDeadBand, 16'hFFFF);
      add_target(1'b0, 16'sd800);
      add_target(1'b0, 16'sd800);
      add_target(1'b1, -16'sd900);
      // deadzone edges
      add_csr(msrl_pkg::CsrDeadBand, 16'd100);
      add_target(1'b0, 16'sd0);
      add_target(1'b0, 16'sd0);
      add_target(1'b0, 16'sd100);
      add_target(1'b0, 16'sd101);
      add_target(1'b1, -16'sd101);
      add_target(1'b1, -16'sd100);
      add_target(1'b1, -16'sd2000);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      csr_open = 1'b0;
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == RowCsr) begin
            if (!csr_open) begin
               drain_results();
               csr_open = 1'b1;
            end
            write_csr(row.index, row.data);
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               @(negedge clock);
               csr_open = 1'b0;
            end
            send_target(row.req, row.typed, row.want);
         end
      end

      // random phases, each with a fresh register setting
      sent = 0;
      while (sent < RandomItems) begin
         drain_results();
         write_csr(msrl_pkg::CsrAccelStep, random_csr(msrl_pkg::CsrAccelStep));
         write_csr(msrl_pkg::CsrDecelStep, random_csr(msrl_pkg::CsrDecelStep));
         write_csr(msrl_pkg::CsrSpeedUpper, random_csr(msrl_pkg::CsrSpeedUpper));
         write_csr(msrl_pkg::CsrSpeedLower, random_csr(msrl_pkg::CsrSpeedLower));
         write_csr(msrl_pkg::CsrDeadBand, random_csr(msrl_pkg::CsrDeadBand));
         if ($urandom_range(0, 2) == 0) begin
            write_csr(msrl_pkg::CsrIndexW'($urandom_range(CsrNoRegFirst, CsrNoRegLast)),
                      16'($urandom));
         end
         csr_valid <= 1'b0;
         @(negedge clock);
         send_idle_on = $urandom_range(0, 2) != 0;
         recv_idle_on = $urandom_range(0, 2) != 0;
         left = $urandom_range(80, 160);
         if (left > RandomItems - sent) begin
            left = RandomItems - sent;
         end
         repeat (left) begin
            // occasional full drain mid-phase
            if ($urandom_range(0, 63) == 0) begin
               drain_results();
            end
            rq.channel = 1'($urandom_range(0, 1));
            rq.target_speed = choose_target(rq.channel);
            send_target(rq, 1'b0, '0);
            sent++;
         end
      end

      drain_results();
      repeat (TailCycles) @(negedge clock);
      if (pending_drive.size() != 0) begin
         mismatch_count++;
         $display("%0d expected items never arrived", pending_drive.size());
      end
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
